[hdl/assert_macros.svh]
// Assertion helpers shared by the formatter modules.
// Each helper checks on the rising clock edge and stays quiet while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check a consequence in the next cycle
`define ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

[hdl/pif_pkg.sv]
package pif_pkg;

  // Field widths of a request and a character
  localparam int VAL_W     = 64;
  localparam int FW_W      = 6;
  localparam int PREC_W    = 7;
  localparam int OP_W      = 3;
  localparam int CHAR_W    = 8;
  localparam int FLAG_CNT  = 3;
  localparam int IN_DATA_W = ((VAL_W + FW_W + PREC_W + FLAG_CNT + 7) / 8) * 8;

  // Saturation limits
  localparam int MAX_FIELD_WIDTH = 60;
  localparam int MAX_PRECISION   = 60;

  // Digit store: 22 octal digits cover 64 bits, decimal needs 20, hex 16
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 22;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VAL_W);

  // Longest conversion: "0x" plus a padded field of 60
  localparam int MAX_CHARS = MAX_FIELD_WIDTH + 2;
  localparam int POS_W     = $clog2(MAX_CHARS + 1);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef enum logic [OP_W-1:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_OCT  = 3'd2,
    OP_HEXL = 3'd3,
    OP_HEXU = 3'd4,
    OP_PTR  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // Request to the digit converter
  typedef struct packed {
    logic              start;
    radix_e            radix;
    logic [VAL_W-1:0]  value;
  } conv_req_t;

  // Status from the digit converter
  typedef struct packed {
    logic            done;
    logic [ND_W-1:0] nd;
  } conv_sts_t;

  // Map one digit to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    if (d < 4'd10) begin
      return CH_ZERO + {4'h0, d};
    end
    return (upper ? CH_UPPER_A : CH_LOWER_A) + {4'h0, d} - 8'd10;
  endfunction

endpackage

[hdl/printf_integer_formatter.sv]
// Integer conversion formatter: takes one request (operation in tuser; value, width,
// precision and the left-align, zero-pad and plus-sign flags in tdata) and sends the
// formatted ASCII text one character per transaction, tlast on the final character.
// Requests are handled one at a time: a request is accepted, converted bit-serially (one
// value bit per cycle through the digit shift chain, then a completion flag), the field
// is planned and then its characters are sent, 1 to 62 of them, one per cycle while the
// output side is ready. Operation codes 6 and 7 are accepted and dropped without
// output.
`include "assert_macros.svh"

module printf_integer_formatter #(
  parameter int FIELD_WIDTH_MAX = pif_pkg::MAX_FIELD_WIDTH,
  parameter int PRECISION_MAX   = pif_pkg::MAX_PRECISION
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // value[63:0], field_width[69:64], precision[76:70], left_align[77],
  // zero_pad[78], plus_sign[79]
  input  logic [pif_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // operation[2:0]
  input  logic [pif_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // character[7:0]
  output logic [pif_pkg::CHAR_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast
);
  import pif_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN,
    ST_EMIT
  } state_e;

  localparam int PW = POS_W + 1;

  // Request fields
  op_e               op_in;
  logic [VAL_W-1:0]  value_in;
  logic [FW_W-1:0]   fw_in;
  logic [PREC_W-1:0] prec_in;
  logic              left_in;
  logic              zpad_in;
  logic              plus_in;

  logic              op_ok;
  logic              is_sdec;
  logic              is_ptr;
  logic              neg_in;
  logic [VAL_W-1:0]  mag_in;
  logic [FW_W-1:0]   width_sat;
  logic [FW_W-1:0]   width_in;
  logic [FW_W-1:0]   prec_sat;
  logic              pc_in;
  logic [1:0]        plen_in;
  radix_e            radix_in;
  logic              accept;

  // Registered request attributes
  state_e            state_q;
  logic              left_q;
  logic              zpad_q;
  logic              prec_given_q;
  logic [FW_W-1:0]   prec_q;
  logic [FW_W-1:0]   width_q;
  logic              pc_q;
  logic [1:0]        plen_q;
  logic              neg_q;
  logic              ptr_q;
  logic              upper_q;

  // Field plan: segment boundaries in character positions
  logic [POS_W-1:0]  b1_q, b2_q, b3_q, b4_q, total_q;
  logic [PW-1:0]     nd_w, zeros_c, spaces_c, used_c;
  logic [PW-1:0]     b1_c, b2_c, b3_c, b4_c, total_c;

  // Emission
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  dig_pos;
  logic [CHAR_W-1:0] char_c;
  logic              last_c;
  logic              emit_fire;
  logic              m_valid_q;
  logic [CHAR_W-1:0] m_data_q;
  logic              m_last_q;

  conv_req_t         conv_req;
  conv_sts_t         conv_sts;
  digits_t           digits;

  // Unpack the request
  assign op_in    = op_e'(s_axis_tuser);
  assign value_in = s_axis_tdata[VAL_W-1:0];
  assign fw_in    = s_axis_tdata[VAL_W +: FW_W];
  assign prec_in  = s_axis_tdata[VAL_W + FW_W +: PREC_W];
  assign left_in  = s_axis_tdata[VAL_W + FW_W + PREC_W];
  assign zpad_in  = s_axis_tdata[VAL_W + FW_W + PREC_W + 1];
  assign plus_in  = s_axis_tdata[VAL_W + FW_W + PREC_W + 2];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_ok         = (s_axis_tuser <= OP_PTR);
  assign is_sdec       = (op_in == OP_SDEC);
  assign is_ptr        = (op_in == OP_PTR);
  assign neg_in        = is_sdec && value_in[VAL_W-1];
  assign mag_in        = neg_in ? (~value_in + VAL_W'(1)) : value_in;

  // Saturate width and precision, take two off a pointer's width for the prefix
  always_comb begin
    width_sat = (fw_in > FW_W'(FIELD_WIDTH_MAX)) ? FW_W'(FIELD_WIDTH_MAX) : fw_in;
    width_in  = width_sat;
    if (is_ptr) begin
      width_in = (width_sat > FW_W'(2)) ? width_sat - FW_W'(2) : '0;
    end
    prec_sat = (prec_in[FW_W-1:0] > FW_W'(PRECISION_MAX)) ? FW_W'(PRECISION_MAX)
                                                          : prec_in[FW_W-1:0];
    pc_in   = is_sdec && (neg_in || plus_in);
    plen_in = is_ptr ? 2'd2 : {1'b0, pc_in};
  end

  // Pick the digit base
  always_comb begin
    unique case (op_in)
      OP_SDEC, OP_UDEC: radix_in = RADIX_DEC;
      OP_OCT:           radix_in = RADIX_OCT;
      default:          radix_in = RADIX_HEX;
    endcase
  end

  assign conv_req.start = accept && op_ok;
  assign conv_req.radix = radix_in;
  assign conv_req.value = mag_in;

  pif_digit_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (conv_req),
    .sts_o    (conv_sts),
    .digits_o (digits)
  );

  // Size the zero and space runs from the digit count
  always_comb begin
    nd_w    = PW'(conv_sts.nd);
    zeros_c = '0;
    if (prec_given_q && PW'(prec_q) > nd_w) begin
      zeros_c = PW'(prec_q) - nd_w;
    end
    if (zpad_q && !left_q && !prec_given_q && PW'(width_q) > nd_w + PW'(pc_q)) begin
      zeros_c = PW'(width_q) - nd_w - PW'(pc_q);
    end
    used_c   = nd_w + zeros_c + PW'(pc_q);
    spaces_c = (PW'(width_q) > used_c) ? PW'(width_q) - used_c : '0;
    b1_c     = left_q ? '0 : spaces_c;
    b2_c     = b1_c + PW'(plen_q);
    b3_c     = b2_c + zeros_c;
    b4_c     = b3_c + nd_w;
    total_c  = b4_c + (left_q ? spaces_c : '0);
  end

  // Choose the character at the current position
  assign dig_pos = b4_q - pos_q - POS_W'(1);

  always_comb begin
    priority if (pos_q < b1_q) begin
      char_c = CH_SPACE;
    end else if (pos_q < b2_q) begin
      if (ptr_q) begin
        char_c = (pos_q == b1_q) ? CH_ZERO : CH_X;
      end else begin
        char_c = neg_q ? CH_MINUS : CH_PLUS;
      end
    end else if (pos_q < b3_q) begin
      char_c = CH_ZERO;
    end else if (pos_q < b4_q) begin
      char_c = digit_char(digits[dig_pos[DIG_IDX_W-1:0]], upper_q);
    end else begin
      char_c = CH_SPACE;
    end
  end

  assign last_c    = (pos_q == total_q - POS_W'(1));
  assign emit_fire = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && !emit_fire) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && op_ok) begin
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_sts.done) begin
            state_q <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          pos_q   <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            m_valid_q <= 1'b1;
            m_data_q  <= char_c;
            m_last_q  <= last_c;
            pos_q     <= pos_q + POS_W'(1);
            if (last_c) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Hold the request attributes and the field plan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q       <= left_in;
      zpad_q       <= zpad_in;
      prec_given_q <= !prec_in[PREC_W-1];
      prec_q       <= prec_sat;
      width_q      <= width_in;
      pc_q         <= pc_in;
      plen_q       <= plen_in;
      neg_q        <= neg_in;
      ptr_q        <= is_ptr;
      upper_q      <= (op_in == OP_HEXU);
    end
    if (state_q == ST_PLAN) begin
      b1_q    <= b1_c[POS_W-1:0];
      b2_q    <= b2_c[POS_W-1:0];
      b3_q    <= b3_c[POS_W-1:0];
      b4_q    <= b4_c[POS_W-1:0];
      total_q <= total_c[POS_W-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  `ASSERT_IMPLIES(a_pos_in_range, clk_i, rst_ni, state_q == ST_EMIT, pos_q < total_q, "character position past the field")
  `ASSERT_IMPLIES(a_done_in_conv, clk_i, rst_ni, conv_sts.done, state_q == ST_CONV, "conversion finished outside the conversion state")
  `ASSERT_NEXT(a_last_ends_item, clk_i, rst_ni, emit_fire && last_c, (state_q == ST_IDLE) && m_axis_tlast, "final character did not end the request")

endmodule

[hdl/pif_digit_conv.sv]
`include "assert_macros.svh"

module pif_digit_conv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pif_pkg::conv_req_t req_i,
  output pif_pkg::conv_sts_t sts_o,
  output pif_pkg::digits_t   digits_o
);
  import pif_pkg::*;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VAL_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [BIT_CNT_W-1:0] bit_cnt_q;
  logic [ND_W-1:0]      nd_q;
  radix_e               radix_q;
  logic [VAL_W-1:0]     val_q;
  digits_t              dig_q;
  digits_t              dig_d;
  logic [NUM_DIGITS-1:0] carry;
  logic                 grow;

  // Shift one value bit into the digit chain, correcting decimal digits first
  always_comb begin
    logic [DIGIT_W-1:0] corr;
    carry    = '0;
    carry[0] = val_q[VAL_W-1];
    for (int i = 0; i < NUM_DIGITS; i++) begin
      corr = dig_q[i];
      if (radix_q == RADIX_DEC && dig_q[i] >= 4'd5) begin
        corr = dig_q[i] + 4'd3;
      end
      if (radix_q == RADIX_OCT) begin
        dig_d[i] = {1'b0, dig_q[i][1:0], carry[i]};
        if (i < NUM_DIGITS - 1) begin
          carry[i+1] = dig_q[i][2];
        end
      end else begin
        dig_d[i] = {corr[2:0], carry[i]};
        if (i < NUM_DIGITS - 1) begin
          carry[i+1] = corr[3];
        end
      end
    end
  end

  // The value only grows, so at most the next digit up turns nonzero
  assign grow = (nd_q < ND_W'(NUM_DIGITS)) && (dig_d[nd_q[DIG_IDX_W-1:0]] != '0);

  // Control: bit counter, digit count, completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      bit_cnt_q <= '0;
      nd_q      <= ND_W'(1);
      radix_q   <= RADIX_DEC;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q    <= 1'b1;
        bit_cnt_q <= '0;
        nd_q      <= ND_W'(1);
        radix_q   <= req_i.radix;
      end else if (busy_q) begin
        bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
        if (grow) begin
          nd_q <= nd_q + ND_W'(1);
        end
        if (bit_cnt_q == LAST_BIT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Data: value shift register and digit store
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      val_q <= req_i.value;
      dig_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[VAL_W-2:0], 1'b0};
      dig_q <= dig_d;
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.nd   = nd_q;
  assign digits_o   = dig_q;

  `ASSERT_ALWAYS(a_nd_range, clk_i, rst_ni, (nd_q != '0) && (nd_q <= ND_W'(NUM_DIGITS)), "digit count out of range")
  `ASSERT_IMPLIES(a_start_idle, clk_i, rst_ni, req_i.start, !busy_q, "conversion started while busy")
  `ASSERT_IMPLIES(a_done_after_busy, clk_i, rst_ni, done_q, $past(busy_q) && !busy_q, "done without a finished conversion")

endmodule

[bench/formatter_bench_pkg.sv]
package formatter_bench_pkg;
  import pif_pkg::*;

  // Operation codes the block drops without output
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  // Precision code for "not given"
  localparam logic [PREC_W-1:0] PREC_NONE = 7'h7F;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VAL_W-1:0]  value;
    logic [FW_W-1:0]   field_width;
    logic [PREC_W-1:0] precision;
    logic              left_align;
    logic              zero_pad;
    logic              plus_sign;
  } fmt_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } fmt_char_t;

  class format_scoreboard;
    fmt_char_t expected_chars[$];
    int errors;
    int requests;
    int dropped;
    int chars_seen;

    function new();
      errors = 0;
      requests = 0;
      dropped = 0;
      chars_seen = 0;
    endfunction

    function void add_char(logic [CHAR_W-1:0] ch);
      fmt_char_t c;
      c.character = ch;
      c.last = 1'b0;
      expected_chars.push_back(c);
    endfunction

    // Build the text that one accepted request must produce
    function void note_request(fmt_req_t r);
      int width;
      int prec;
      int nd;
      int sign_chars;
      int zeros;
      int spaces;
      logic neg;
      logic is_ptr;
      logic [VAL_W-1:0] mag;
      logic [CHAR_W-1:0] digs[24];
      string digit_set;

      requests++;
      if (r.op > OP_PTR) begin
        dropped++;
        return;
      end

      width = (int'(r.field_width) > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(r.field_width);
      if (r.precision[PREC_W-1]) begin
        prec = -1;
      end else begin
        prec = (int'(r.precision) > MAX_PRECISION) ? MAX_PRECISION : int'(r.precision);
      end

      is_ptr = (r.op == OP_PTR);
      neg = (r.op == OP_SDEC) && r.value[VAL_W-1];
      mag = neg ? -r.value : r.value;
      digit_set = (r.op == OP_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";

      // Collect digits, least significant first
      nd = 0;
      do begin
        case (r.op)
          OP_OCT: begin
            digs[nd] = digit_set[mag[2:0]];
            mag = mag >> 3;
          end
          OP_SDEC, OP_UDEC: begin
            digs[nd] = digit_set[int'(mag % 64'd10)];
            mag = mag / 64'd10;
          end
          default: begin
            digs[nd] = digit_set[mag[3:0]];
            mag = mag >> 4;
          end
        endcase
        nd++;
      end while (mag != 0);

      // Plan the field
      if (is_ptr) width = (width > 2) ? width - 2 : 0;
      sign_chars = ((r.op == OP_SDEC) && (neg || r.plus_sign)) ? 1 : 0;
      zeros = (prec > nd) ? prec - nd : 0;
      if (r.zero_pad && !r.left_align && prec < 0 && width > nd + sign_chars) begin
        zeros = width - nd - sign_chars;
      end
      spaces = width - nd - zeros - sign_chars;
      if (spaces < 0) spaces = 0;

      // Lay out the characters
      if (!r.left_align) begin
        for (int i = 0; i < spaces; i++) add_char(CH_SPACE);
      end
      if (is_ptr) begin
        add_char(CH_ZERO);
        add_char(CH_X);
      end else if (sign_chars != 0) begin
        add_char(neg ? CH_MINUS : CH_PLUS);
      end
      for (int i = 0; i < zeros; i++) add_char(CH_ZERO);
      for (int i = nd - 1; i >= 0; i--) add_char(digs[i]);
      if (r.left_align) begin
        for (int i = 0; i < spaces; i++) add_char(CH_SPACE);
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    // Compare one output transaction with the oldest expected character
    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      fmt_char_t want;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character 0x%02h (last %0b) with nothing pending", ch, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.character) begin
        $error("character: expected 0x%02h, got 0x%02h", want.character, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // Flag characters that never showed up
    function void check_drained();
      if (expected_chars.size() != 0) begin
        $error("%0d expected characters never arrived", expected_chars.size());
        errors++;
      end
    endfunction
  endclass

endpackage

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pif_pkg::*;
  import formatter_bench_pkg::*;

  localparam int RANDOM_REQUESTS = 500;
  localparam int QUIET_TAIL      = 100;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 150;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;

  logic rx_stall_on = 1'b0;
  logic tx_gap_on = 1'b0;

  format_scoreboard sb;

  printf_integer_formatter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check every accepted character
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // Drop tready in random bursts while stalls are enabled
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Abort when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic fmt_req_t make_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                            logic [FW_W-1:0] fw, logic [PREC_W-1:0] prec,
                                            logic left, logic zpad, logic sign);
    fmt_req_t r;
    r.op = op;
    r.value = value;
    r.field_width = fw;
    r.precision = prec;
    r.left_align = left;
    r.zero_pad = zpad;
    r.plus_sign = sign;
    return r;
  endfunction

  function automatic fmt_req_t random_request();
    fmt_req_t r;
    if ($urandom_range(0, 15) == 0) begin
      r.op = OP_W'($urandom_range(6, 7));
    end else begin
      r.op = OP_W'($urandom_range(0, 5));
    end
    case ($urandom_range(0, 4))
      0: r.value = {$urandom, $urandom};
      1: r.value = VAL_W'($urandom_range(0, 1000));
      2: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: begin
        case ($urandom_range(0, 3))
          0: r.value = '0;
          1: r.value = '1;
          2: r.value = 64'h8000_0000_0000_0000;
          default: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: r.value = -VAL_W'($urandom_range(1, 1000));
    endcase
    // Mostly short fields, now and then the widest
    if ($urandom_range(0, 3) == 0) begin
      r.field_width = FW_W'($urandom_range(0, 63));
    end else begin
      r.field_width = FW_W'($urandom_range(0, 24));
    end
    case ($urandom_range(0, 3))
      0: r.precision = PREC_NONE;
      1: r.precision = PREC_W'($urandom_range(64, 127));
      2: r.precision = PREC_W'($urandom_range(0, 24));
      default: r.precision = PREC_W'($urandom_range(0, 63));
    endcase
    r.left_align = 1'($urandom_range(0, 1));
    r.zero_pad = 1'($urandom_range(0, 1));
    r.plus_sign = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(fmt_req_t r);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.op;
    s_axis_tdata <= {r.plus_sign, r.zero_pad, r.left_align, r.precision, r.field_width,
                     r.value};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  // Insert a random sender gap when gaps are enabled
  task automatic maybe_gap();
    if (tx_gap_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
  endtask

  // Hold off until every pending character has arrived
  task automatic drain_output();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    fmt_req_t directed_set[$];
    fmt_req_t r;
    int accepted;

    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners: extremes, every operation, saturation, flag interplay
    directed_set.push_back(make_request(OP_SDEC, 64'h8000_0000_0000_0000, 6'd0, PREC_NONE,
                                        1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_SDEC, '1, 6'd5, PREC_NONE, 1'b0, 1'b1, 1'b0));
    directed_set.push_back(make_request(OP_SDEC, '0, 6'd0, 7'd0, 1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 6'd25, PREC_NONE,
                                        1'b0, 1'b0, 1'b1));
    directed_set.push_back(make_request(OP_SDEC, 64'd42, 6'd10, 7'd6, 1'b1, 1'b1, 1'b1));
    directed_set.push_back(make_request(OP_SDEC, 64'd7, 6'd4, PREC_NONE, 1'b0, 1'b0, 1'b1));
    directed_set.push_back(make_request(OP_SDEC, 64'd123, 6'd8, 7'h40, 1'b0, 1'b1, 1'b0));
    directed_set.push_back(make_request(OP_UDEC, '1, 6'd0, PREC_NONE, 1'b0, 1'b0, 1'b1));
    directed_set.push_back(make_request(OP_UDEC, '0, 6'd63, 7'd63, 1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_UDEC, 64'd99, 6'd63, 7'd62, 1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_OCT, '1, 6'd60, PREC_NONE, 1'b1, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_OCT, 64'd8, 6'd30, PREC_NONE, 1'b0, 1'b1, 1'b1));
    directed_set.push_back(make_request(OP_HEXL, 64'h0123_4567_89AB_CDEF, 6'd0, 7'd20,
                                        1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_HEXU, 64'hFEDC_BA98_7654_3210, 6'd18, PREC_NONE,
                                        1'b0, 1'b1, 1'b0));
    directed_set.push_back(make_request(OP_PTR, '0, 6'd0, PREC_NONE, 1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_PTR, 64'hDEAD, 6'd1, PREC_NONE, 1'b0, 1'b0, 1'b1));
    directed_set.push_back(make_request(OP_PTR, 64'hBEEF, 6'd2, PREC_NONE, 1'b0, 1'b1, 1'b0));
    directed_set.push_back(make_request(OP_PTR, 64'hCAFE, 6'd20, PREC_NONE, 1'b0, 1'b1, 1'b0));
    directed_set.push_back(make_request(OP_PTR, '1, 6'd63, PREC_NONE, 1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_PTR, 64'h1234, 6'd12, 7'd6, 1'b1, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_RSVD_LO, 64'd5, 6'd10, PREC_NONE,
                                        1'b0, 1'b0, 1'b0));
    directed_set.push_back(make_request(OP_RSVD_HI, '1, 6'd63, 7'd60, 1'b1, 1'b1, 1'b1));
    directed_set.push_back(make_request(OP_HEXL, 64'd0, 6'd3, 7'd0, 1'b1, 1'b0, 1'b0));

    rx_stall_on = 1'b1;
    tx_gap_on = 1'b1;
    foreach (directed_set[i]) begin
      send_request(directed_set[i]);
      maybe_gap();
    end
    drain_output();

    // Random requests; stall pattern changes every 50, quiet tail at the end
    accepted = 0;
    while (accepted < RANDOM_REQUESTS) begin
      if (accepted % 50 == 0) begin
        if (accepted >= RANDOM_REQUESTS - QUIET_TAIL) begin
          rx_stall_on = 1'b0;
          tx_gap_on = 1'b0;
        end else begin
          rx_stall_on = ($urandom_range(0, 2) != 0);
          tx_gap_on = ($urandom_range(0, 2) != 0);
        end
      end
      r = random_request();
      send_request(r);
      if (r.op <= OP_PTR) accepted++;
      if (tx_gap_on && $urandom_range(0, 59) == 0) begin
        drain_output();
      end else begin
        maybe_gap();
      end
    end

    drain_output();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.check_drained();

    $display("Covered %0d requests (%0d with reserved codes), %0d characters checked,",
             sb.requests, sb.dropped, sb.chars_seen);
    $display("with random stalls and gaps on both sides and a stall-free tail.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
